[hw/rtl/ilir_pkg.sv]
package ilir_pkg;

    localparam int POS_BITS       = 5;
    localparam int VALUE_BITS     = 32;
    localparam int COUNT_OUT_BITS = 5;
    localparam int KIND_BITS      = 2;
    localparam int STATUS_BITS    = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // broadcast command to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_INSERT     = 3'd1,
        CELL_REMOVE     = 3'd2,
        CELL_READ_LOAD  = 3'd3,
        CELL_READ_SHIFT = 3'd4
    } t_cell_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

endpackage

[hw/rtl/ilir_cell.sv]
module ilir_cell #(
    parameter int WORD_BITS = 32,
    parameter int PW        = 5,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  ilir_pkg::t_cell_op   i_op,
    input  logic [PW-1:0]        i_pos,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    input  logic [WORD_BITS-1:0] i_rd_right,
    output logic [WORD_BITS-1:0] o_data,
    output logic [WORD_BITS-1:0] o_rd
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        case (i_op)
            ilir_pkg::CELL_INSERT: begin
                if (MY_IDX == i_pos) begin
                    r_data <= i_word;
                end else if (MY_IDX > i_pos) begin
                    r_data <= i_left;
                end
            end
            ilir_pkg::CELL_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    r_data <= i_right;
                end
            end
            // every cell copies its entry, then the copies walk toward cell 0
            ilir_pkg::CELL_READ_LOAD: begin
                r_rd <= r_data;
            end
            ilir_pkg::CELL_READ_SHIFT: begin
                r_rd <= i_rd_right;
            end
            default: begin
            end
        endcase
    end

    assign o_data = r_data;
    assign o_rd   = r_rd;

endmodule

[hw/rtl/indexed_list_insert_remove.sv]
// Packed list of signed words held in a chain of cells, one entry per cell.
// Input channel (i_in_valid / o_in_ready) carries one command per transaction:
// append, insert at index, remove at index or read at index. Output channel
// (o_out_valid / i_out_ready) returns one result per command: status, read
// value and the entry count after the command.
// Append, insert, remove and out-of-range reads finish in the accept cycle:
// the result is loaded into the output register at acceptance, and a
// new command can be taken every cycle while the receiver takes results.
// An in-range read at index p walks the chain: all cells copy their
// entries into a read line that shifts one cell toward cell 0 per cycle, so
// the entry reaches cell 0 after p shifts. No command is taken meanwhile.
// Cells at or past the index move their entries in the same cycle, so an
// insert or remove costs the same whatever the index.
// Reset empties the list (count 0) and drops the output valid; entry
// contents are not cleared and are never visible past the count.
// When the receiver stalls, the result is held in the output register and
// o_in_ready drops until it is taken.
module indexed_list_insert_remove #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  logic [ilir_pkg::KIND_BITS-1:0]              i_kind,
    input  logic [ilir_pkg::POS_BITS-1:0]               i_position,
    input  logic signed [ilir_pkg::VALUE_BITS-1:0]      i_value,
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic [ilir_pkg::STATUS_BITS-1:0]            o_status,
    output logic signed [ilir_pkg::VALUE_BITS-1:0]      o_read_value,
    output logic [ilir_pkg::COUNT_OUT_BITS-1:0]         o_item_count
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = (IW > ilir_pkg::POS_BITS) ? IW : ilir_pkg::POS_BITS;
    localparam int CMPW = (CW > ilir_pkg::POS_BITS) ? CW : ilir_pkg::POS_BITS;

    ilir_pkg::t_state   r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_hops, n_hops;

    logic                                   r_out_valid;
    ilir_pkg::t_status                      r_status;
    logic signed [ilir_pkg::VALUE_BITS-1:0] r_read_value;
    logic [ilir_pkg::COUNT_OUT_BITS-1:0]    r_item_count;

    logic                                   accept;
    logic                                   load_out;
    ilir_pkg::t_status                      out_status;
    logic signed [ilir_pkg::VALUE_BITS-1:0] out_rd;
    ilir_pkg::t_cell_op                     cell_op;
    logic [PW-1:0]                          cell_pos;
    logic [CMPW-1:0]                        pos_c;
    logic [CMPW-1:0]                        cnt_c;
    logic [CMPW-1:0]                        n_count_c;
    logic                                   full;
    logic signed [63:0]                     value_wide;
    logic [WORD_BITS-1:0]                   word;
    logic signed [WORD_BITS-1:0]            rd_head;
    logic signed [63:0]                     rd_wide;

    logic [WORD_BITS-1:0] cell_data [CAPACITY];
    logic [WORD_BITS-1:0] cell_rd   [CAPACITY];

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ilir_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);

    assign pos_c     = CMPW'(i_position);
    assign cnt_c     = CMPW'(r_count);
    assign n_count_c = CMPW'(n_count);
    assign full      = cnt_c >= CMPW'(CAPACITY);

    assign value_wide = 64'(i_value);
    assign word       = value_wide[WORD_BITS-1:0];
    assign rd_head    = cell_rd[0];
    assign rd_wide    = 64'(rd_head);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_hops     = r_hops;
        load_out   = 1'b0;
        out_status = ilir_pkg::STATUS_DONE;
        out_rd     = '0;
        cell_op    = ilir_pkg::CELL_HOLD;
        cell_pos   = PW'(i_position);
        case (r_state)
            ilir_pkg::ST_IDLE: begin
                if (accept) begin
                    case (ilir_pkg::t_kind'(i_kind))
                        ilir_pkg::KIND_APPEND: begin
                            load_out = 1'b1;
                            if (full) begin
                                out_status = ilir_pkg::STATUS_FULL;
                            end else begin
                                // append is an insert at the tail
                                cell_op  = ilir_pkg::CELL_INSERT;
                                cell_pos = PW'(r_count);
                                n_count  = r_count + CW'(1);
                            end
                        end
                        ilir_pkg::KIND_INSERT: begin
                            load_out = 1'b1;
                            if (pos_c > cnt_c) begin
                                out_status = ilir_pkg::STATUS_RANGE;
                            end else if (full) begin
                                out_status = ilir_pkg::STATUS_FULL;
                            end else begin
                                cell_op = ilir_pkg::CELL_INSERT;
                                n_count = r_count + CW'(1);
                            end
                        end
                        ilir_pkg::KIND_REMOVE: begin
                            load_out = 1'b1;
                            if (pos_c >= cnt_c) begin
                                out_status = ilir_pkg::STATUS_RANGE;
                            end else begin
                                cell_op = ilir_pkg::CELL_REMOVE;
                                n_count = r_count - CW'(1);
                            end
                        end
                        ilir_pkg::KIND_READ: begin
                            if (pos_c >= cnt_c) begin
                                load_out   = 1'b1;
                                out_status = ilir_pkg::STATUS_RANGE;
                                out_rd     = '1;
                            end else begin
                                cell_op = ilir_pkg::CELL_READ_LOAD;
                                n_hops  = pos_c[IW-1:0];
                                n_state = ilir_pkg::ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ilir_pkg::ST_READ: begin
                if (r_hops == '0) begin
                    load_out = 1'b1;
                    out_rd   = rd_wide[ilir_pkg::VALUE_BITS-1:0];
                    n_state  = ilir_pkg::ST_IDLE;
                end else begin
                    cell_op = ilir_pkg::CELL_READ_SHIFT;
                    n_hops  = r_hops - IW'(1);
                end
            end
            default: begin
                n_state = ilir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilir_pkg::ST_IDLE;
            r_count <= '0;
            r_hops  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hops  <= n_hops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status     <= out_status;
            r_read_value <= out_rd;
            r_item_count <= n_count_c[ilir_pkg::COUNT_OUT_BITS-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;
    assign o_item_count = r_item_count;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_BITS-1:0] left;
        logic [WORD_BITS-1:0] right;
        logic [WORD_BITS-1:0] rd_right;

        if (i == 0) begin : g_head
            assign left = '0;
        end else begin : g_body
            assign left = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right    = '0;
            assign rd_right = '0;
        end else begin : g_next
            assign right    = cell_data[i+1];
            assign rd_right = cell_rd[i+1];
        end

        ilir_cell #(
            .WORD_BITS (WORD_BITS),
            .PW        (PW),
            .IDX       (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_op       (cell_op),
            .i_pos      (cell_pos),
            .i_word     (word),
            .i_left     (left),
            .i_right    (right),
            .i_rd_right (rd_right),
            .o_data     (cell_data[i]),
            .o_rd       (cell_rd[i])
        );
    end

    // the list never grows past its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(CAPACITY))
        else $error("entry count above capacity");

    // the count moves only on an accepted transaction
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("entry count changed without a transaction");

    // a read walking the chain always finds the output register free
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ilir_pkg::ST_READ |-> !r_out_valid)
        else $error("output register busy during read");

    // commands other than an in-range read answer in the next cycle
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (n_state == ilir_pkg::ST_IDLE) |=> r_out_valid)
        else $error("missing result after single-cycle command");

endmodule
